// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the geohash encoder.
// Included by files that carry concurrent assertions; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define GH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset
`define GH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GH_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/ghenc_pkg.sv
// Package of the geohash encoder: field widths, range constants, alphabet.
// No dependencies.
package ghenc_pkg;

    localparam int COORD_W         = 36;
    localparam int COUNT_W         = 8;
    localparam int CHAR_W          = 7;
    localparam int DIGIT_W         = 5;
    localparam int MAX_SYMBOLS_DEF = 12;

    // Full bisection span (-R..R) is 2R; R = 180 deg * 2^27 = 90 deg * 2^28
    localparam logic [COORD_W-1:0]          SPAN_FULL   = 36'd48318382080;
    localparam logic signed [COORD_W+1:0]   SPAN_HALF_S = 38'sd24159191040;
    localparam logic signed [COORD_W+1:0]   SPAN_FULL_S = 38'sd48318382080;

    // Geohash base32 alphabet, ASCII
    localparam logic [CHAR_W-1:0] GH_ALPHABET [0:31] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
        7'h68, 7'h6A, 7'h6B, 7'h6D, 7'h6E, 7'h70, 7'h71, 7'h72,
        7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A
    };

    function automatic logic [CHAR_W-1:0] ghenc_char(input logic [DIGIT_W-1:0] digit);
        return GH_ALPHABET[digit];
    endfunction

endpackage

// File: hdl/ghenc_in_if.sv
// Input channel of the geohash encoder: coordinate pair and precision.
// Depends on ghenc_pkg.
interface ghenc_in_if;
    import ghenc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] lon_fixed;
    logic signed [COORD_W-1:0] lat_fixed;
    logic [COUNT_W-1:0]        symbol_count;

    modport source (output valid, lon_fixed, lat_fixed, symbol_count, input ready);
    modport sink   (input valid, lon_fixed, lat_fixed, symbol_count, output ready);
endinterface

// File: hdl/ghenc_out_if.sv
// Output channel of the geohash encoder: one ASCII character per item.
// Depends on ghenc_pkg.
interface ghenc_out_if;
    import ghenc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] symbol_char;
    logic              last_symbol;

    modport source (output valid, symbol_char, last_symbol, input ready);
    modport sink   (input valid, symbol_char, last_symbol, output ready);
endinterface

// File: hdl/ghenc_bisect.sv
// Bit-serial bisection of one coordinate, one decision bit per step.
// Depends on ghenc_pkg.
module ghenc_bisect (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic signed [ghenc_pkg::COORD_W-1:0] i_value,
    input  logic                                 i_step,
    output logic                                 o_bit
);
    import ghenc_pkg::*;

    // Remainder of the offset value, always within 0..2R
    logic [COORD_W-1:0]        r_rem, n_rem;
    logic signed [COORD_W+1:0] w_off;
    logic [COORD_W:0]          w_dbl;
    logic [COORD_W:0]          w_sub;

    // Offset into 0..2R before saturation
    assign w_off = (COORD_W+2)'(i_value) + SPAN_HALF_S;

    // Doubling the remainder and comparing to 2R is the same as comparing to the midpoint
    assign w_dbl = {r_rem, 1'b0};
    assign w_sub = w_dbl - {1'b0, SPAN_FULL};
    assign o_bit = (w_dbl >= {1'b0, SPAN_FULL});

    // Load with saturation, then restoring step
    always_comb begin
        n_rem = r_rem;
        if (i_load) begin
            if (w_off < 0) begin
                n_rem = '0;
            end else if (w_off > SPAN_FULL_S) begin
                n_rem = SPAN_FULL;
            end else begin
                n_rem = w_off[COORD_W-1:0];
            end
        end else if (i_step) begin
            n_rem = o_bit ? w_sub[COORD_W-1:0] : w_dbl[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end
endmodule

// File: hdl/ghenc_symbol.sv
// Interleaved bit stream of the geohash and the base32 character at its head.
// Depends on ghenc_pkg.
module ghenc_symbol #(
    parameter int MAX_SYMBOLS = ghenc_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_push,
    input  logic [1:0]                    i_pair,
    input  logic                          i_pop,
    output logic [ghenc_pkg::CHAR_W-1:0]  o_char
);
    import ghenc_pkg::*;

    localparam int BIS_STEPS = (DIGIT_W * MAX_SYMBOLS + 1) / 2;
    localparam int STREAM_W  = 2 * BIS_STEPS;

    logic [STREAM_W-1:0] r_stream, n_stream;

    // Push a {lon, lat} pair at the bottom, pop one digit off the top
    always_comb begin
        n_stream = r_stream;
        if (i_push) begin
            n_stream = {r_stream[STREAM_W-3:0], i_pair};
        end else if (i_pop) begin
            n_stream = {r_stream[STREAM_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_stream <= n_stream;
    end

    assign o_char = ghenc_char(r_stream[STREAM_W-1 -: DIGIT_W]);
endmodule

// File: hdl/geohash_encoder.sv
// Geohash encoder top level: control, two bisectors, stream, output register.
// Depends on ghenc_pkg, ghenc_in_if, ghenc_out_if, ghenc_bisect, ghenc_symbol, assert_macros.svh.
//
//   channel  | dir | payload                                 | per item
//   ---------+-----+-----------------------------------------+-----------------
//   i_in     | in  | lon_fixed, lat_fixed, symbol_count      | one
//   o_out    | out | symbol_char, last_symbol                | 1..MAX_SYMBOLS
//
// An item loads both bisectors, which then make one bit per coordinate per cycle for
// all MAX_SYMBOLS characters; then the P requested characters leave, one per cycle while
// o_out does not stall. The next item is taken as soon as the last character sits in
// the output register. Reset clears control only; a stall on o_out holds the emit stage.
`include "assert_macros.svh"

module geohash_encoder #(
    parameter int MAX_SYMBOLS = ghenc_pkg::MAX_SYMBOLS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ghenc_in_if.sink     i_in,
    ghenc_out_if.source  o_out
);
    import ghenc_pkg::*;

    localparam int BIS_STEPS = (DIGIT_W * MAX_SYMBOLS + 1) / 2;
    localparam int STEP_W    = $clog2(BIS_STEPS);
    localparam int SYM_W     = $clog2(MAX_SYMBOLS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_BISECT = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [SYM_W-1:0]  r_left, n_left;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;

    logic              w_accept;
    logic              w_stepping;
    logic              w_load_out;
    logic              w_last_load;
    logic [SYM_W-1:0]  w_prec;
    logic              w_lon_bit;
    logic              w_lat_bit;
    logic [CHAR_W-1:0] w_char;

    // Handshakes
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid & i_in.ready;
    assign w_stepping  = (r_state == ST_BISECT);
    assign w_load_out  = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);
    assign w_last_load = w_load_out && (r_left == SYM_W'(1));

    // Precision: zero or too large means the maximum
    always_comb begin
        if (i_in.symbol_count == '0 || i_in.symbol_count > COUNT_W'(MAX_SYMBOLS)) begin
            w_prec = SYM_W'(MAX_SYMBOLS);
        end else begin
            w_prec = i_in.symbol_count[SYM_W-1:0];
        end
    end

    // Bisectors
    ghenc_bisect u_lon (
        .i_clk   (i_clk),
        .i_load  (w_accept),
        .i_value (i_in.lon_fixed),
        .i_step  (w_stepping),
        .o_bit   (w_lon_bit)
    );

    ghenc_bisect u_lat (
        .i_clk   (i_clk),
        .i_load  (w_accept),
        .i_value (i_in.lat_fixed),
        .i_step  (w_stepping),
        .o_bit   (w_lat_bit)
    );

    // Interleaved stream, longitude first
    ghenc_symbol #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_symbol (
        .i_clk  (i_clk),
        .i_push (w_stepping),
        .i_pair ({w_lon_bit, w_lat_bit}),
        .i_pop  (w_load_out),
        .o_char (w_char)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_BISECT;
                    n_step  = '0;
                    n_left  = w_prec;
                end
            end
            ST_BISECT: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(BIS_STEPS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_left      = r_left - 1'b1;
                    if (r_left == SYM_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_char <= w_char;
            r_out_last <= w_last_load;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.symbol_char = r_out_char;
    assign o_out.last_symbol = r_out_last;

    // Checks
    `GH_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == ST_BISECT && r_left != '0)
    `GH_ASSERT_IMP(a_emit_has_work, i_clk, i_rst_n, r_state == ST_EMIT, r_left != '0)
    `GH_ASSERT_NEXT(a_last_flagged, i_clk, i_rst_n, w_last_load, r_out_valid && r_out_last && i_in.ready)
    `GH_ASSERT_IMP(a_left_bounded, i_clk, i_rst_n, r_state == ST_BISECT, r_left <= SYM_W'(MAX_SYMBOLS))
endmodule
